[hdl/pemu_pkg.sv]
// Shared types and constants of the pulse energy meter update block.
package pemu_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned ScaleW = 32;
  localparam int unsigned TotalW = 48;
  localparam int unsigned EnergyW = 64;
  localparam int unsigned CfgIdxW = 3;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegPowerScale   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCurrentScale = 3'd1;
  localparam logic [CfgIdxW-1:0] RegVoltageScale = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEnergyScale  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSwitchPeriod = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInitCurMode  = 3'd5;

  localparam logic [1:0] WarmupDone = 2'd2;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef struct packed {
    logic [CntW-1:0] power_pulses;
    logic [CntW-1:0] aux_pulses;
  } pemu_in_t;

  typedef struct packed {
    logic               reading_valid;
    logic [ScaleW-1:0]  power_value;
    logic               aux_valid;
    logic               aux_is_current;
    logic [ScaleW-1:0]  aux_value;
    logic [EnergyW-1:0] energy_value;
    logic               select_level;
  } pemu_out_t;

  typedef struct packed {
    logic [ScaleW-1:0] power_scale;
    logic [ScaleW-1:0] current_scale;
    logic [ScaleW-1:0] voltage_scale;
    logic [ScaleW-1:0] energy_scale;
    logic [CntW-1:0]   switch_period;
  } pemu_cfg_t;

  // One interval after the state update, counts already masked
  typedef struct packed {
    logic              reading_valid;
    logic [CntW-1:0]   power_cnt;
    logic              aux_valid;
    logic              aux_is_current;
    logic [CntW-1:0]   aux_cnt;
    logic [TotalW-1:0] total;
    logic              select_level;
  } pemu_item_t;

endpackage

[hdl/pemu_track.sv]
// Configuration registers and per-interval state (warm-up, mode switching, pulse total).
module pemu_track (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pemu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pemu_pkg::ScaleW-1:0]   cfg_data_i,
  input  logic                          accept_i,
  input  pemu_pkg::pemu_in_t            in_word_i,
  output pemu_pkg::pemu_cfg_t           cfg_o,
  output pemu_pkg::pemu_item_t          item_o
);
  import pemu_pkg::*;

  pemu_cfg_t         cfg_q;
  logic [1:0]        warm_q, warm_d;
  logic              mode_q, mode_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TotalW-1:0] total_q, total_d;

  logic              warm_done;
  logic              hit;
  logic [TotalW:0]   total_sum;

  assign warm_done = (warm_q == WarmupDone);
  assign hit       = (cnt_q == cfg_q.switch_period);
  assign total_sum = {1'b0, total_q} + {{(TotalW-CntW+1){1'b0}}, in_word_i.power_pulses};

  always_comb begin
    warm_d  = warm_q;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    if (!warm_done) begin
      warm_d = warm_q + 2'd1;
    end else begin
      total_d = total_sum[TotalW] ? TotalMax : total_sum[TotalW-1:0];
      if (cfg_q.switch_period != '0) begin
        cnt_d  = hit ? '0 : cnt_q + 1'b1;
        mode_d = mode_q ^ hit;
      end
    end
  end

  // Item for the scaling pipeline; zero counts stand for no reading
  always_comb begin
    item_o = '0;
    item_o.select_level = mode_d;
    if (warm_done) begin
      item_o.reading_valid = 1'b1;
      item_o.power_cnt = (in_word_i.power_pulses <= 16'd1) ? '0 : in_word_i.power_pulses;
      item_o.total = total_d;
      if (cnt_q != '0 || cfg_q.switch_period == '0) begin
        item_o.aux_valid      = 1'b1;
        item_o.aux_is_current = mode_q;
        item_o.aux_cnt = (in_word_i.aux_pulses <= 16'd1) ? '0 : in_word_i.aux_pulses;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      warm_q  <= '0;
      mode_q  <= 1'b1;
      cnt_q   <= '0;
      total_q <= '0;
    end else begin
      if (accept_i) begin
        warm_q  <= warm_d;
        cnt_q   <= cnt_d;
        total_q <= total_d;
      end
      // a write of the initial mode loads the mode at once
      if (cfg_we_i && cfg_index_i == RegInitCurMode) begin
        mode_q <= cfg_data_i[0];
      end else if (accept_i) begin
        mode_q <= mode_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegPowerScale:   cfg_q.power_scale   <= cfg_data_i;
          RegCurrentScale: cfg_q.current_scale <= cfg_data_i;
          RegVoltageScale: cfg_q.voltage_scale <= cfg_data_i;
          RegEnergyScale:  cfg_q.energy_scale  <= cfg_data_i;
          RegSwitchPeriod: cfg_q.switch_period <= cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o = cfg_q;

  a_warm_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !warm_done |=> warm_q == $past(warm_q) + 2'd1)
    else $error("warm-up count did not advance");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && cfg_q.switch_period == '0 |=> $stable(cnt_q))
    else $error("switch count moved with switching disabled");

  a_mode_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (!warm_done || !hit || cfg_q.switch_period == '0)
      && !(cfg_we_i && cfg_index_i == RegInitCurMode) |=> $stable(mode_q))
    else $error("mode toggled without a switch hit");

endmodule

[hdl/pemu_scale.sv]
// Scaling pipeline: item register, product register and output register with stall flow.
module pemu_scale (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pemu_pkg::pemu_cfg_t   cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pemu_pkg::pemu_item_t  item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pemu_pkg::pemu_out_t   out_word_o
);
  import pemu_pkg::*;

  typedef struct packed {
    logic                reading_valid;
    logic [TotalW-1:0]   power_prod;
    logic                aux_valid;
    logic                aux_is_current;
    logic [TotalW-1:0]   aux_prod;
    logic [EnergyW-1:0]  energy_hi;
    logic [TotalW-1:0]   energy_lo;
    logic                select_level;
  } pemu_prod_t;

  pemu_item_t  s1_q;
  logic        s1_vld_q;
  pemu_prod_t  s2_q, s2_d;
  logic        s2_vld_q;
  pemu_out_t   out_q, out_d;
  logic        out_vld_q;

  logic s1_ld, s2_ld, out_ld;
  logic [ScaleW-1:0]  aux_scale;
  logic [EnergyW-1:0] lo_full;
  logic [EnergyW:0]   energy_sum;

  assign out_ld = !out_vld_q || !out_stall_i;
  assign s2_ld  = !s2_vld_q || out_ld;
  assign s1_ld  = !s1_vld_q || s2_ld;
  assign in_stall_o = !s1_ld;

  // Multiply stage
  assign aux_scale = s1_q.aux_is_current ? cfg_i.current_scale : cfg_i.voltage_scale;
  assign lo_full = {{(EnergyW-TotalW){1'b0}}, s1_q.total}
                 * {{(EnergyW-16){1'b0}}, cfg_i.energy_scale[15:0]};

  always_comb begin
    s2_d.reading_valid  = s1_q.reading_valid;
    s2_d.aux_valid      = s1_q.aux_valid;
    s2_d.aux_is_current = s1_q.aux_is_current;
    s2_d.select_level   = s1_q.select_level;
    s2_d.power_prod = {{(TotalW-CntW){1'b0}}, s1_q.power_cnt}
                    * {{(TotalW-ScaleW){1'b0}}, cfg_i.power_scale};
    s2_d.aux_prod   = {{(TotalW-CntW){1'b0}}, s1_q.aux_cnt}
                    * {{(TotalW-ScaleW){1'b0}}, aux_scale};
    s2_d.energy_hi  = {{(EnergyW-TotalW){1'b0}}, s1_q.total}
                    * {{(EnergyW-16){1'b0}}, cfg_i.energy_scale[31:16]};
    s2_d.energy_lo  = lo_full[EnergyW-1:16];
  end

  // Sum and clamp stage
  assign energy_sum = {1'b0, s2_q.energy_hi}
                    + {{(EnergyW-TotalW+1){1'b0}}, s2_q.energy_lo};

  always_comb begin
    out_d.reading_valid  = s2_q.reading_valid;
    out_d.power_value    = s2_q.power_prod[TotalW-1:16];
    out_d.aux_valid      = s2_q.aux_valid;
    out_d.aux_is_current = s2_q.aux_is_current;
    out_d.aux_value      = s2_q.aux_prod[TotalW-1:16];
    out_d.energy_value   = energy_sum[EnergyW] ? {EnergyW{1'b1}} : energy_sum[EnergyW-1:0];
    out_d.select_level   = s2_q.select_level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_ld)  s1_vld_q  <= in_valid_i;
      if (s2_ld)  s2_vld_q  <= s1_vld_q;
      if (out_ld) out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ld && in_valid_i) s1_q  <= item_i;
    if (s2_ld && s1_vld_q)   s2_q  <= s2_d;
    if (out_ld && s2_vld_q)  out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q && s2_vld_q && out_vld_q)
    else $error("input stalled with a free stage");

  a_warm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.reading_valid |->
      out_q.power_value == '0 && !out_q.aux_valid && out_q.energy_value == '0)
    else $error("warm-up word carries a reading");

  a_aux_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.aux_valid |-> out_q.aux_value == '0 && !out_q.aux_is_current)
    else $error("unpublished second channel not cleared");

endmodule

[hdl/pulse_energy_meter_update_top.sv]
// Top level of the pulse energy meter update block.
// Path: an accepted word passes the item register, product register and
//   output register in order to out_valid_o; an output stall can hold it.
// Throughput: one word per cycle; input stalls only when all three stages hold
//   words and the output is stalled.
// Reset: asynchronous, active low; scales and switch period clear, current mode set,
//   warm-up, switch count and pulse total cleared, pipeline emptied.
module pulse_energy_meter_update_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pemu_pkg::pemu_in_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pemu_pkg::pemu_out_t          out_word_o,
  input  logic                         cfg_we_i,
  input  logic [pemu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pemu_pkg::ScaleW-1:0]  cfg_data_i
);
  import pemu_pkg::*;

  pemu_cfg_t  cfg;
  pemu_item_t item;
  logic       accept;

  // A word is taken when valid and not stalled; the state advances at that edge
  assign accept = in_valid_i && !in_stall_o;

  // Hold configuration and interval state; build the masked item for scaling
  pemu_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_word_i   (in_word_i),
    .cfg_o       (cfg),
    .item_o      (item)
  );

  // Multiply by the Q16.16 scales, then sum and clamp into the output register
  pemu_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
